@@ hdl/pic_pkg.sv @@
// shared constants, types and the priority pick function
// of the priority interrupt controller; no dependencies
package pic_pkg;

   localparam int NUM_SOURCES = 32;
   localparam int NEST_DEPTH  = 8;
   localparam int SRC_W       = 5;
   localparam int PRIO_W      = 3;
   localparam int CNT_W       = $clog2(NEST_DEPTH + 1);
   localparam int NIDX_W      = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
   localparam int RAM_AW      = SRC_W + 1;
   localparam int RAM_DEPTH   = 1 << RAM_AW;

   localparam logic [63:0] VALID_WIDE = (64'd1 << NUM_SOURCES) - 64'd1;
   localparam logic [31:0] VALID_MASK = VALID_WIDE[31:0];

   // item kinds
   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_LINE  = 2'd2;

   // register offsets
   localparam logic [8:0] OFF_IVR   = 9'h100;
   localparam logic [8:0] OFF_FVR   = 9'h104;
   localparam logic [8:0] OFF_ISR   = 9'h108;
   localparam logic [8:0] OFF_IPR   = 9'h10C;
   localparam logic [8:0] OFF_IMR   = 9'h110;
   localparam logic [8:0] OFF_CISR  = 9'h114;
   localparam logic [8:0] OFF_IECR  = 9'h120;
   localparam logic [8:0] OFF_IDCR  = 9'h124;
   localparam logic [8:0] OFF_ICCR  = 9'h128;
   localparam logic [8:0] OFF_ISCR  = 9'h12C;
   localparam logic [8:0] OFF_EOICR = 9'h130;
   localparam logic [8:0] OFF_SPU   = 9'h134;
   localparam logic [8:0] OFF_DCR   = 9'h138;
   localparam logic [8:0] OFF_FFER  = 9'h140;
   localparam logic [8:0] OFF_FFDR  = 9'h144;
   localparam logic [8:0] OFF_FFSR  = 9'h148;

   localparam int DBG_PROTECT_BIT = 0;
   localparam int DBG_GMASK_BIT   = 1;
   localparam int MODE_EDGE_BIT   = 5;

   typedef logic [NUM_SOURCES-1:0][PRIO_W-1:0] prio_vec_type;

   typedef struct packed {
      logic [SRC_W-1:0]  src;
      logic [PRIO_W-1:0] prio;
   } pick_type;

   typedef struct packed {
      logic              we;
      logic [RAM_AW-1:0] waddr;
      logic [31:0]       wdata;
      logic              re;
      logic [RAM_AW-1:0] raddr;
   } ram_ctl_type;

   // highest priority wins, lowest source number on a tie, source 0 skipped
   function automatic pick_type pick_best(input logic [31:0] cand,
                                          input prio_vec_type prio);
      logic [7:0][NUM_SOURCES-1:0] lvl;
      logic [NUM_SOURCES-1:0]      sel;
      pick_type                    res;
      lvl = '0;
      sel = '0;
      res = '0;
      for (int i = 1; i < NUM_SOURCES; i++) begin
         lvl[prio[i]][i] = cand[i];
      end
      for (int p = 0; p < 8; p++) begin
         if (|lvl[p]) begin
            sel = lvl[p];
            res.prio = PRIO_W'(p);
         end
      end
      for (int i = NUM_SOURCES - 1; i >= 1; i--) begin
         if (sel[i]) begin
            res.src = SRC_W'(i);
         end
      end
      return res;
   endfunction

endpackage

@@ hdl/pic_ram.sv @@
// word memory holding source mode words and vector words
// depends on pic_pkg for widths and the control struct
module pic_ram (
   input  logic                      clock,
   input  pic_pkg::ram_ctl_type      ctl,
   output logic [31:0]               rd_data_ff
);

   logic [31:0] mem [pic_pkg::RAM_DEPTH];

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem[ctl.waddr] <= ctl.wdata;
      end
      if (ctl.re) begin
         rd_data_ff <= mem[ctl.raddr];
      end
   end

endmodule

@@ hdl/priority_interrupt_controller.sv @@
// top level of the 32-source priority interrupt controller
// depends on pic_pkg and pic_ram
//
// usage:
//  - req channel: one transfer per item; tuser carries the kind (read, write,
//    line change), tdata carries offset, write data, line number and level
//  - rsp channel: one transfer per item with read data and irq/fiq levels
//  - every item passes an accept cycle that issues the word memory read (mode
//    or vector word) and an execute cycle that updates the state and
//    recomputes the request outputs; the next item is taken right after
//  - the result sits in an output register; a new item is accepted while the
//    previous result waits, and execute holds until that register is free
//  - reset clears all control registers, the nesting count and the memory
//    valid bits, so every mode and vector word reads as zero until written
//  - a stalled receiver holds the result stable and blocks at most one
//    further item in its execute cycle
//  - the priority pick runs on flop copies of the priority fields; the edge bits are kept as flop copies too
module priority_interrupt_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // offset[8:0], wdata[40:9], line[45:41], level[46]
   input  logic [1:0]  req_tuser,  // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata   // rdata[31:0], irq_out[32], fiq_out[33]
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;

   // latched item
   logic [1:0]  kind_ff;
   logic [8:0]  off_ff;
   logic [31:0] wdat_ff;
   logic [4:0]  line_ff;
   logic        level_ff;
   pic_pkg::pick_type best_ff;

   // controller state
   logic [31:0] pend_ff, pend_in;
   logic [31:0] en_ff, en_in;
   logic [31:0] ff_ff, ff_in;
   logic [31:0] spu_ff, spu_in;
   logic [31:0] dcr_ff, dcr_in;
   logic [1:0]  cstat_ff, cstat_in;
   logic [pic_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [pic_pkg::NEST_DEPTH-1:0][pic_pkg::SRC_W-1:0]  nsrc_ff;
   logic [pic_pkg::NEST_DEPTH-1:0][pic_pkg::PRIO_W-1:0] nprio_ff;
   pic_pkg::prio_vec_type prio_ff, prio_in;
   logic [31:0] edge_ff, edge_in;
   logic [pic_pkg::RAM_DEPTH-1:0] wvalid_ff;
   logic        rd_valid_ff;

   // output register
   logic        rsp_valid_ff;
   logic [39:0] rsp_data_ff;

   pic_pkg::ram_ctl_type ram_ctl;
   logic [31:0] ram_q;
   logic        ram_we;
   logic [pic_pkg::RAM_AW-1:0] ram_raddr;

   logic accept, fire, push;
   pic_pkg::pick_type best_cur, best_nxt;
   logic [31:0] rdata_in;
   logic [pic_pkg::CNT_W-1:0] cnt_m1, cnt_in_m1;
   logic [2:0]  top_prio;
   logic [31:0] req_n, fmask_n;
   logic [8:0]  req_off;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign fire       = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign req_off    = req_tdata[8:0];

   // pick on the state as it stands when the item arrives
   assign best_cur = pic_pkg::pick_best(pend_ff & en_ff & ~ff_ff & pic_pkg::VALID_MASK
                                        & ~32'd1, prio_ff);

   pic_ram u_ram (
      .clock      (clock),
      .ctl        (ram_ctl),
      .rd_data_ff (ram_q)
   );

   assign cnt_m1 = cnt_ff - pic_pkg::CNT_W'(1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // read address: mode word, vector word, picked vector or vector 0
   always_comb begin
      ram_raddr = '0;
      priority if (req_off[8:7] == 2'b00) begin
         ram_raddr = {1'b0, req_off[6:2]};
      end else if (req_off[8:7] == 2'b01) begin
         ram_raddr = {1'b1, req_off[6:2]};
      end else if (req_off == pic_pkg::OFF_IVR) begin
         ram_raddr = {1'b1, best_cur.src};
      end else begin
         ram_raddr = {1'b1, 5'd0};
      end
   end

   // memory port: reads at accept, writes at execute
   always_comb begin
      ram_ctl.we    = ram_we;
      ram_ctl.waddr = {off_ff[7], off_ff[6:2]};
      ram_ctl.wdata = wdat_ff;
      ram_ctl.re    = accept;
      ram_ctl.raddr = ram_raddr;
   end

   // execute: state update and read data
   always_comb begin
      logic push_req;
      pend_in  = pend_ff;
      en_in    = en_ff;
      ff_in    = ff_ff;
      spu_in   = spu_ff;
      dcr_in   = dcr_ff;
      prio_in  = prio_ff;
      edge_in  = edge_ff;
      cnt_in   = cnt_ff;
      rdata_in = '0;
      push_req = 1'b0;
      ram_we   = 1'b0;

      unique case (kind_ff)
         pic_pkg::KIND_READ: begin
            if (off_ff[8] == 1'b0) begin
               rdata_in = rd_valid_ff ? ram_q : 32'd0;
            end else begin
               unique case (off_ff)
                  pic_pkg::OFF_IVR: begin
                     push_req = !dcr_ff[pic_pkg::DBG_PROTECT_BIT];
                     rdata_in = (best_ff.src == '0) ? spu_ff
                                : (rd_valid_ff ? ram_q : 32'd0);
                  end
                  pic_pkg::OFF_FVR: begin
                     if (pend_ff[0]) begin
                        pend_in[0] = 1'b0;
                        rdata_in   = rd_valid_ff ? ram_q : 32'd0;
                     end else if (|(pend_ff & ff_ff)) begin
                        rdata_in   = rd_valid_ff ? ram_q : 32'd0;
                     end else begin
                        rdata_in   = spu_ff;
                     end
                  end
                  pic_pkg::OFF_ISR: begin
                     rdata_in = (cnt_ff == '0) ? 32'd0
                                : 32'(nsrc_ff[cnt_m1[pic_pkg::NIDX_W-1:0]]);
                  end
                  pic_pkg::OFF_IPR:  rdata_in = pend_ff;
                  pic_pkg::OFF_IMR:  rdata_in = en_ff;
                  pic_pkg::OFF_CISR: rdata_in = {30'd0, cstat_ff};
                  pic_pkg::OFF_SPU:  rdata_in = spu_ff;
                  pic_pkg::OFF_DCR:  rdata_in = dcr_ff;
                  pic_pkg::OFF_FFSR: rdata_in = ff_ff;
                  default:           rdata_in = 32'd0;
               endcase
            end
         end
         pic_pkg::KIND_WRITE: begin
            if (off_ff[8] == 1'b0) begin
               ram_we = 1'b1;
               if (off_ff[7] == 1'b0) begin
                  prio_in[off_ff[6:2]] = wdat_ff[pic_pkg::PRIO_W-1:0];
                  edge_in[off_ff[6:2]] = wdat_ff[pic_pkg::MODE_EDGE_BIT];
               end
            end else begin
               unique case (off_ff)
                  pic_pkg::OFF_IVR:   push_req = dcr_ff[pic_pkg::DBG_PROTECT_BIT];
                  pic_pkg::OFF_IECR:  en_in = en_ff | (wdat_ff & pic_pkg::VALID_MASK);
                  pic_pkg::OFF_IDCR:  en_in = en_ff & ~wdat_ff;
                  pic_pkg::OFF_ICCR:  pend_in = pend_ff & ~(wdat_ff & edge_ff);
                  pic_pkg::OFF_ISCR:  pend_in = pend_ff | (wdat_ff & edge_ff);
                  pic_pkg::OFF_EOICR: begin
                     if (cnt_ff != '0) begin
                        cnt_in = cnt_m1;
                     end
                  end
                  pic_pkg::OFF_SPU:   spu_in = wdat_ff;
                  pic_pkg::OFF_DCR:   dcr_in = wdat_ff;
                  pic_pkg::OFF_FFER:  ff_in = ff_ff | (wdat_ff & pic_pkg::VALID_MASK);
                  pic_pkg::OFF_FFDR:  ff_in = ff_ff & ~wdat_ff;
                  default: ;
               endcase
            end
         end
         pic_pkg::KIND_LINE: begin
            if (level_ff) begin
               pend_in[line_ff] = 1'b1;
            end else if (!edge_ff[line_ff]) begin
               pend_in[line_ff] = 1'b0;
            end
         end
         default: ;
      endcase

      // push the picked source on the nesting stack
      push = push_req && (cnt_ff < pic_pkg::CNT_W'(pic_pkg::NEST_DEPTH))
             && (best_ff.src != '0);
      if (push) begin
         cnt_in = cnt_ff + pic_pkg::CNT_W'(1);
         if (edge_ff[best_ff.src]) begin
            pend_in[best_ff.src] = 1'b0;
         end
      end
      ram_we = ram_we && fire;
   end

   // request outputs on the updated state
   assign req_n     = pend_in & en_in;
   assign fmask_n   = 32'd1 | ff_in;
   assign best_nxt  = pic_pkg::pick_best(pend_in & en_in & ~ff_in & pic_pkg::VALID_MASK
                                         & ~32'd1, prio_in);
   assign cnt_in_m1 = cnt_in - pic_pkg::CNT_W'(1);
   assign top_prio  = push ? best_ff.prio : nprio_ff[cnt_in_m1[pic_pkg::NIDX_W-1:0]];

   always_comb begin
      cstat_in = 2'b00;
      if (!dcr_in[pic_pkg::DBG_GMASK_BIT]) begin
         cstat_in[0] = |(req_n & fmask_n);
         cstat_in[1] = (|(req_n & ~fmask_n))
                       && ((cnt_in == '0) || (top_prio < best_nxt.prio));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= '0;
         en_ff        <= '0;
         ff_ff        <= '0;
         spu_ff       <= '0;
         dcr_ff       <= '0;
         cstat_ff     <= '0;
         cnt_ff       <= '0;
         prio_ff      <= '0;
         edge_ff      <= '0;
         wvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (fire) begin
            pend_ff  <= pend_in;
            en_ff    <= en_in;
            ff_ff    <= ff_in;
            spu_ff   <= spu_in;
            dcr_ff   <= dcr_in;
            cstat_ff <= cstat_in;
            cnt_ff   <= cnt_in;
            prio_ff  <= prio_in;
            edge_ff  <= edge_in;
            if (ram_ctl.we) begin
               wvalid_ff[ram_ctl.waddr] <= 1'b1;
            end
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff     <= req_tuser;
         off_ff      <= req_tdata[8:0];
         wdat_ff     <= req_tdata[40:9];
         line_ff     <= req_tdata[45:41];
         level_ff    <= req_tdata[46];
         best_ff     <= best_cur;
         rd_valid_ff <= wvalid_ff[ram_ctl.raddr];
      end
      if (fire) begin
         rsp_data_ff <= {6'd0, cstat_in[0], cstat_in[1], rdata_in};
         if (push) begin
            nsrc_ff[cnt_ff[pic_pkg::NIDX_W-1:0]]  <= best_ff.src;
            nprio_ff[cnt_ff[pic_pkg::NIDX_W-1:0]] <= best_ff.prio;
         end
      end
   end

endmodule

@@ hdl/pic_checker.sv @@
// port-level checks for the priority interrupt controller
// bound to priority_interrupt_controller; no package use
module pic_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // one item at a time: no accept right after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted in execute cycle");

   // no result straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

   // padding bits stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[39:34] == 6'd0)
      else $error("result padding not zero");

endmodule

bind priority_interrupt_controller pic_checker u_pic_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
